// ===== src/block_cache_second_chance_unit_assert.svh =====
// Assertion macros for the block cache unit.
`ifndef BLOCK_CACHE_SECOND_CHANCE_UNIT_ASSERT_SVH
`define BLOCK_CACHE_SECOND_CHANCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BC_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define BC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define BC_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define BC_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== src/bcsc_pkg.sv =====
package bcsc_pkg;
  typedef enum logic [1:0] {
    OP_GET = 2'd0, OP_PREFETCH = 2'd1, OP_RELEASE = 2'd2, OP_FLUSH = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sector;
    logic        make_dirty;
    logic        halt_flag;
  } req_t;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic        hit;
    logic        write_back;
    logic [31:0] write_sector;
    logic        fill;
    logic        no_victim;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK_RD, ST_LOOK, ST_HIT, ST_ALLOC, ST_SCAN_RD, ST_SCAN,
    ST_FL_RD, ST_FL, ST_FL_END, ST_OUT
  } state_t;
endpackage

// ===== src/bcsc_if.sv =====
interface bcsc_req_if;
  import bcsc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bcsc_rsp_if;
  import bcsc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/block_cache_second_chance_unit.sv =====
// Block cache tag and second-chance policy engine.
// in_ch carries requests (get, prefetch, release, flush); out_ch carries
// result beats, each with last marking the final beat of a request.
// One request at a time. Tags and per-slot state sit in synchronous
// memories read one slot per cycle, so a lookup walks the valid slots
// one at a time, reading each slot and then comparing its tag. A get or
// prefetch miss on a full cache adds a victim scan of up to two passes
// (2*ENTRIES slot reads). A flush walks every valid slot and emits one
// beat per dirty slot, or a single beat when no slot is dirty.
// Reset clears used count and control state; per-slot pin, dirty and
// accessed fields reset via a valid bit per slot (tags are undefined
// until written). When the receiver stalls, the result register holds
// its beat, the next beat waits in a staging register and the walk
// pauses; no request is accepted until the current one is done.
module block_cache_second_chance_unit #(
  parameter int ENTRIES = 64
) (
  input logic clk,
  input logic rst_n,
  bcsc_req_if.sink in_ch,
  bcsc_rsp_if.source out_ch
);
  import bcsc_pkg::*;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // memories: tag and policy word {pin, dirty, accessed}
  logic [31:0] tag_mem [ENTRIES];
  logic [9:0]  pol_mem [ENTRIES];
  logic [ENTRIES-1:0] pol_vld_r;
  logic [31:0] tag_q;
  logic [9:0]  pol_raw_q;
  logic        pol_vq;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_tag, wr_pol;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_tag_d;
  logic [9:0]    wr_pol_d;
  logic          clr_all;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_q <= tag_mem[rd_addr];
      pol_raw_q <= pol_mem[rd_addr];
    end
    if (wr_tag) tag_mem[wr_addr] <= wr_tag_d;
    if (wr_pol) pol_mem[wr_addr] <= wr_pol_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      pol_vld_r <= '0;
      pol_vq <= 1'b0;
    end else begin
      if (rd_en) pol_vq <= pol_vld_r[rd_addr];
      if (wr_pol) pol_vld_r[wr_addr] <= 1'b1;
    end
  end

  logic [9:0] pol_q;
  assign pol_q = pol_vq ? pol_raw_q : 10'd0;

  // control registers
  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  rsp_t   rsp_r, rsp_nxt;
  rsp_t   bld_r, bld_nxt;
  rsp_t   fl_r, fl_nxt;
  logic   ov_r, ov_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          any_unp_r, any_unp_nxt;
  logic          any_fl_r, any_fl_nxt;
  state_t        ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      used_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      used_r <= used_nxt;
    end
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
    bld_r <= bld_nxt;
    fl_r <= fl_nxt;
    idx_r <= idx_nxt;
    any_unp_r <= any_unp_nxt;
    any_fl_r <= any_fl_nxt;
    ret_r <= ret_nxt;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = rsp_r;

  logic [7:0] pin_q;
  logic       last_idx;
  assign pin_q = pol_q[9:2];
  assign last_idx = (CW'(idx_r) == CW'(used_r - CW'(1))) || (used_r == '0);

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    rsp_nxt = rsp_r;
    bld_nxt = bld_r;
    fl_nxt = fl_r;
    ov_nxt = ov_r;
    used_nxt = used_r;
    idx_nxt = idx_r;
    any_unp_nxt = any_unp_r;
    any_fl_nxt = any_fl_r;
    ret_nxt = ret_r;
    rd_en = 1'b0;
    rd_addr = idx_r;
    wr_tag = 1'b0;
    wr_pol = 1'b0;
    wr_addr = idx_r;
    wr_tag_d = req_r.sector;
    wr_pol_d = '0;
    clr_all = 1'b0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.data;
          idx_nxt = '0;
          any_unp_nxt = 1'b0;
          any_fl_nxt = 1'b0;
          bld_nxt = '0;
          bld_nxt.last = 1'b1;
          if (in_ch.data.operation == OP_FLUSH) begin
            state_nxt = (used_r == '0) ? ST_OUT : ST_FL_RD;
            ret_nxt = ST_IDLE;
          end else state_nxt = (used_r == '0) ? ST_ALLOC : ST_LOOK_RD;
        end
      end
      // lookup walk over valid slots
      ST_LOOK_RD: begin
        rd_en = 1'b1;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (tag_q == req_r.sector) state_nxt = ST_HIT;
        else if (last_idx) state_nxt = ST_ALLOC;
        else begin
          idx_nxt = idx_r + IW'(1);
          state_nxt = ST_LOOK_RD;
        end
      end
      ST_HIT: begin
        bld_nxt.entry_index = 6'(idx_r);
        bld_nxt.hit = 1'b1;
        wr_pol_d = pol_q;
        if (req_r.operation == OP_GET) begin
          wr_pol = 1'b1;
          if (pin_q != 8'hFF) wr_pol_d[9:2] = pin_q + 8'd1;
          wr_pol_d[1] = pol_q[1] | req_r.make_dirty;
          wr_pol_d[0] = 1'b1;
        end else if (req_r.operation == OP_RELEASE) begin
          wr_pol = 1'b1;
          if (pin_q != 8'd0) wr_pol_d[9:2] = pin_q - 8'd1;
        end
        state_nxt = ST_OUT;
        ret_nxt = ST_IDLE;
      end
      ST_ALLOC: begin
        if (req_r.operation == OP_RELEASE) begin
          state_nxt = ST_OUT;
          ret_nxt = ST_IDLE;
        end else if (used_r != CW'(ENTRIES)) begin
          wr_addr = IW'(used_r);
          wr_tag = 1'b1;
          wr_pol = 1'b1;
          wr_pol_d = {(req_r.operation == OP_GET) ? 8'd1 : 8'd0,
                      (req_r.operation == OP_GET) & req_r.make_dirty, 1'b1};
          bld_nxt.entry_index = 6'(used_r);
          bld_nxt.fill = 1'b1;
          used_nxt = used_r + CW'(1);
          state_nxt = ST_OUT;
          ret_nxt = ST_IDLE;
        end else begin
          idx_nxt = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      // second-chance victim scan, at most two full passes
      ST_SCAN_RD: begin
        rd_en = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        wr_pol_d = pol_q;
        if (pin_q == 8'd0 && !pol_q[0]) begin
          wr_tag = 1'b1;
          wr_pol = 1'b1;
          wr_pol_d = {(req_r.operation == OP_GET) ? 8'd1 : 8'd0,
                      (req_r.operation == OP_GET) & req_r.make_dirty, 1'b1};
          bld_nxt.entry_index = 6'(idx_r);
          bld_nxt.fill = 1'b1;
          bld_nxt.write_back = pol_q[1];
          bld_nxt.write_sector = pol_q[1] ? tag_q : 32'd0;
          state_nxt = ST_OUT;
          ret_nxt = ST_IDLE;
        end else begin
          if (pin_q == 8'd0) begin
            wr_pol = 1'b1;
            wr_pol_d[0] = 1'b0;
            any_unp_nxt = 1'b1;
          end
          if (idx_r == IW'(ENTRIES - 1)) begin
            idx_nxt = '0;
            if (!(any_unp_r || pin_q == 8'd0)) begin
              bld_nxt.no_victim = 1'b1;
              state_nxt = ST_OUT;
              ret_nxt = ST_IDLE;
            end else state_nxt = ST_SCAN_RD;
          end else begin
            idx_nxt = idx_r + IW'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      // flush walk; the newest dirty beat is held in fl_r until the
      // next dirty slot or the end of the walk shows whether it is last
      ST_FL_RD: begin
        rd_en = 1'b1;
        state_nxt = ST_FL;
      end
      ST_FL: begin
        if (pol_q[1]) begin
          wr_pol = 1'b1;
          wr_pol_d = pol_q;
          wr_pol_d[1] = 1'b0;
          any_fl_nxt = 1'b1;
          fl_nxt = '0;
          fl_nxt.entry_index = 6'(idx_r);
          fl_nxt.write_back = 1'b1;
          fl_nxt.write_sector = tag_q;
          if (any_fl_r) begin
            bld_nxt = fl_r;
            state_nxt = ST_OUT;
            ret_nxt = last_idx ? ST_FL_END : ST_FL_RD;
          end else state_nxt = last_idx ? ST_FL_END : ST_FL_RD;
        end else if (last_idx) begin
          state_nxt = any_fl_r ? ST_FL_END : ST_OUT;
          ret_nxt = ST_IDLE;
        end else state_nxt = ST_FL_RD;
        if (!last_idx) idx_nxt = idx_r + IW'(1);
      end
      ST_FL_END: begin
        bld_nxt = fl_r;
        bld_nxt.last = 1'b1;
        state_nxt = ST_OUT;
        ret_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          rsp_nxt = bld_r;
          state_nxt = ret_r;
          if (ret_r == ST_IDLE && req_r.operation == OP_FLUSH && req_r.halt_flag) begin
            clr_all = 1'b1;
            used_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "block_cache_second_chance_unit_assert.svh"
  `BC_ASSERT_IMPL(a_busy_no_ready, clk, rst_n, state_r != ST_IDLE, !in_ch.ready, "ready while busy")
  `BC_ASSERT_IMPL(a_used_max, clk, rst_n, 1'b1, used_r <= CW'(ENTRIES), "used overflow")
  `BC_ASSERT_NEXT(a_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(rsp_r), "beat lost")
endmodule
